@@ hw/rtl/smvs_pkg.sv @@
// shared types and constants of the set statistics core
`default_nettype none

package smvs_pkg;

	// field widths of the stream beats
	localparam int unsigned SampleW  = 16;
	localparam int unsigned MeanW    = 20;
	localparam int unsigned VarW     = 38;
	localparam int unsigned SdW      = 19;
	localparam int unsigned STdataW  = 16;
	localparam int unsigned MTdataW  = 80;
	localparam int unsigned MPadW    = MTdataW - MeanW - VarW - SdW;

	// controller to datapath commands
	typedef struct packed {
		logic load_sample;
		logic accumulate;
		logic square_sum;
		logic form_var;
		logic root_step;
		logic load_out;
	} smvs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_in_set;
		logic root_done;
	} smvs_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/sample_mean_variance_stddev_core.sv @@
// top level of the set statistics core: mean, variance and standard deviation per set
`default_nettype none

// Groups the incoming sample stream into consecutive sets of SET_SIZE samples
// (a power of two) and sends one result beat per set. With k = log2(SET_SIZE):
// mean_scaled is the set's sum (mean with k fraction bits), variance_scaled is
// SET_SIZE * sum of squares - sum^2 (population variance with 2k fraction
// bits), stddev_scaled is the floor square root of that (deviation with k
// fraction bits). Sample bits above SAMPLE_WIDTH are ignored. Each sample beat
// is captured, then goes through one multiply-accumulate. After the last sample
// of a set come sum squaring, variance subtract, a square root that resolves
// one result bit per cycle, and the handoff into the output register.
// The result sits in an output register until it is taken; the next set's
// samples are accepted meanwhile, and only a second finished set waits for it.

module sample_mean_variance_stddev_core #(
	parameter int unsigned SET_SIZE     = 16,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// sample input stream
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [smvs_pkg::STdataW-1:0]     s_tdata,   // [15:0] sample
	// result output stream
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [smvs_pkg::MTdataW-1:0]     m_tdata    // [19:0] mean_scaled,
	                                                    // [57:20] variance_scaled,
	                                                    // [76:58] stddev_scaled,
	                                                    // [79:77] zero
);
	import smvs_pkg::*;

	smvs_cmd_t        cmd;
	smvs_sts_t        sts;
	logic [MeanW-1:0] mean_scaled;
	logic [VarW-1:0]  variance_scaled;
	logic [SdW-1:0]   stddev_scaled;

	// state machine: one set at a time, handoff through the output register
	smvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// sums, variance, square root and result registers
	smvs_dp #(
		.SET_SIZE     (SET_SIZE),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample          (s_tdata[SampleW-1:0]),
		.cmd             (cmd),
		.sts             (sts),
		.mean_scaled     (mean_scaled),
		.variance_scaled (variance_scaled),
		.stddev_scaled   (stddev_scaled)
	);

	// pack result fields, lowest field first
	assign m_tdata = {{MPadW{1'b0}}, stddev_scaled, variance_scaled, mean_scaled};

endmodule

`default_nettype wire

@@ hw/rtl/smvs_dp.sv @@
// datapath: running sums, variance and bit-serial square root
`default_nettype none

module smvs_dp #(
	parameter int unsigned SET_SIZE     = 16,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [smvs_pkg::SampleW-1:0] sample,
	input  wire  smvs_pkg::smvs_cmd_t   cmd,
	output smvs_pkg::smvs_sts_t         sts,
	output logic [smvs_pkg::MeanW-1:0]  mean_scaled,
	output logic [smvs_pkg::VarW-1:0]   variance_scaled,
	output logic [smvs_pkg::SdW-1:0]    stddev_scaled
);
	import smvs_pkg::*;

	localparam int unsigned K      = $clog2(SET_SIZE);
	localparam int unsigned CNT_W  = (K < 1) ? 1 : K;
	localparam int unsigned SW     = SAMPLE_WIDTH;
	localparam int unsigned SUM_W  = SW + K;
	localparam int unsigned SQ_W   = 2 * SW + K;
	localparam int unsigned V_W    = 2 * SW + 2 * K;
	localparam int unsigned ROOT_W = SW + K;
	localparam int unsigned REM_W  = ROOT_W + 2;
	localparam int unsigned STEP_W = $clog2(ROOT_W);

	logic [SW-1:0]     smp_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sumsq_q;
	logic [V_W-1:0]    sum2_q;
	logic [V_W-1:0]    var_q;
	logic [V_W-1:0]    rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;

	logic [2*SW-1:0]   prod;
	logic [V_W-1:0]    sum_sq;
	logic [REM_W-1:0]  rem_next;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign prod     = smp_q * smp_q;
	assign sum_sq   = V_W'(sum_q) * V_W'(sum_q);
	assign rem_next = {rem_q[REM_W-3:0], rad_q[V_W-1 -: 2]};
	assign trial    = {root_q, 2'b01};
	assign fits     = rem_next >= trial;

	assign sts.last_in_set = (cnt_q == CNT_W'(SET_SIZE - 1));
	assign sts.root_done   = (step_q == STEP_W'(ROOT_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (cmd.load_out) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			sumsq_q <= '0;
		end else if (cmd.accumulate) begin
			cnt_q   <= cnt_q + CNT_W'(1);
			sum_q   <= sum_q + SUM_W'(smp_q);
			sumsq_q <= sumsq_q + SQ_W'(prod);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			smp_q <= SW'(sample);
		end
		if (cmd.square_sum) begin
			sum2_q <= sum_sq;
		end
		if (cmd.form_var) begin
			var_q  <= (V_W'(sumsq_q) << K) - sum2_q;
			rad_q  <= (V_W'(sumsq_q) << K) - sum2_q;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			step_q <= step_q + STEP_W'(1);
			if (fits) begin
				rem_q  <= rem_next - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			mean_scaled     <= MeanW'(sum_q);
			variance_scaled <= VarW'(var_q);
			stddev_scaled   <= SdW'(root_q);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/smvs_ctrl.sv @@
// controller: sequences sample intake, set close-out and result handoff
`default_nettype none

module smvs_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output smvs_pkg::smvs_cmd_t  cmd,
	input  wire smvs_pkg::smvs_sts_t sts
);
	import smvs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_SQR  = 3'd2;
	localparam logic [2:0] ST_VAR  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_sample = 1'b1;
					state_d         = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = sts.last_in_set ? ST_SQR : ST_IDLE;
			end
			ST_SQR: begin
				cmd.square_sum = 1'b1;
				state_d        = ST_VAR;
			end
			ST_VAR: begin
				cmd.form_var = 1'b1;
				state_d      = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench of the set statistics core
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import smvs_pkg::*;

	// set size and full-scale sample value of the instance under test
	localparam int unsigned SetSize   = 16;
	localparam int unsigned SampleMax = 65535;
	// cycles left for the core to settle once nothing is expected
	localparam int unsigned DrainCycles = 60;
	// length of the long receiver hold-off
	localparam int unsigned HoldCycles  = 400;

	// how the values of one random set are chosen
	typedef enum int unsigned {
		FILL_FULL,      // any 16 bit value
		FILL_LOW,       // small values near zero
		FILL_HIGH,      // values near full scale
		FILL_FLAT,      // one value for the whole set, zero spread
		FILL_RAILS      // only zero or full scale
	} set_fill_e;

	// one expected result beat
	typedef struct packed {
		logic [MeanW-1:0] mean_scaled;
		logic [VarW-1:0]  variance_scaled;
		logic [SdW-1:0]   stddev_scaled;
	} set_stats_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [STdataW-1:0] s_tdata  = '0;   // [15:0] sample
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [MTdataW-1:0] m_tdata;         // [19:0] mean, [57:20] variance,
	                                     // [76:58] stddev, [79:77] zero

	// samples waiting to be offered, results waiting to arrive
	logic [STdataW-1:0] pending_samples[$];
	set_stats_t         stats_due[$];

	// running sums of the set in progress, mirrored from the core
	int unsigned  set_fill_count = 0;
	logic [19:0]  set_sum        = '0;
	logic [35:0]  set_square_sum = '0;

	// idling knobs, changed per phase
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	logic        pressure_go    = 1'b0;
	logic        recv_hold      = 1'b0;

	int unsigned error_count = 0;

	sample_mean_variance_stddev_core #(
		.SET_SIZE    (SetSize),
		.SAMPLE_WIDTH(SampleW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// floor square root, one candidate bit at a time from the top
	function automatic logic [SdW-1:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) begin
				root = trial;
			end
		end
		return root[SdW-1:0];
	endfunction

	// add one accepted sample to the set; a full set yields its statistics
	task automatic fold_sample(input logic [STdataW-1:0] raw);
		logic [63:0] s;
		logic [63:0] spread;
		set_stats_t  stats;
		s = 64'(raw[SampleW-1:0]);
		set_sum        = set_sum + 20'(s);
		set_square_sum = set_square_sum + 36'(s * s);
		set_fill_count++;
		if (set_fill_count == SetSize) begin
			// n * sum of squares - sum^2, exact in 64 bits at these sizes
			spread = 64'(SetSize) * 64'(set_square_sum) - 64'(set_sum) * 64'(set_sum);
			stats.mean_scaled     = set_sum;
			stats.variance_scaled = spread[VarW-1:0];
			stats.stddev_scaled   = floor_sqrt(spread);
			stats_due.push_back(stats);
			set_fill_count = 0;
			set_sum        = '0;
			set_square_sum = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// sample driver: offers the next queued sample whenever the slot frees up, with random idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			// a beat taken on this edge goes to the predictor
			if (s_tvalid) begin
				fold_sample(s_tdata);
			end
			if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= pending_samples.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result monitor: checks each taken beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		set_stats_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (stats_due.size() == 0) begin
					report_mismatch("unexpected result beat", 64'(m_tdata[MeanW-1:0]), '0);
				end else begin
					want = stats_due.pop_front();
					if (m_tdata[MeanW-1:0] !== want.mean_scaled) begin
						report_mismatch("mean_scaled", 64'(m_tdata[MeanW-1:0]),
							64'(want.mean_scaled));
					end
					if (m_tdata[MeanW+:VarW] !== want.variance_scaled) begin
						report_mismatch("variance_scaled", 64'(m_tdata[MeanW+:VarW]),
							64'(want.variance_scaled));
					end
					if (m_tdata[MeanW+VarW+:SdW] !== want.stddev_scaled) begin
						report_mismatch("stddev_scaled", 64'(m_tdata[MeanW+VarW+:SdW]),
							64'(want.stddev_scaled));
					end
					if (m_tdata[MTdataW-1-:MPadW] !== '0) begin
						report_mismatch("pad bits", 64'(m_tdata[MTdataW-1-:MPadW]), '0);
					end
				end
			end
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off: results back up until the core stalls its input
	initial begin
		wait (pressure_go);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		recv_hold <= 1'b0;
	end

	// queue n random samples, set by set, each set with its own value shape
	task automatic queue_random(input int unsigned n);
		set_fill_e   fill;
		logic [15:0] flat;
		logic [15:0] v;
		fill = FILL_FULL;
		flat = '0;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % SetSize == 0) begin
				fill = set_fill_e'($urandom_range(FILL_RAILS));
				flat = 16'($urandom);
			end
			case (fill)
				FILL_LOW:   v = 16'($urandom_range(15));
				FILL_HIGH:  v = 16'(SampleMax - $urandom_range(15));
				FILL_FLAT:  v = flat;
				FILL_RAILS: v = $urandom_range(1) ? 16'(SampleMax) : 16'd0;
				default:    v = 16'($urandom);
			endcase
			pending_samples.push_back(v);
		end
	endtask

	task automatic drain_pending();
		while (pending_samples.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// directed: alternating rails give the largest spread and deviation
		for (int unsigned i = 0; i < SetSize; i++) begin
			pending_samples.push_back(i[0] ? 16'(SampleMax) : 16'd0);
		end
		// directed: full scale throughout gives the largest mean, zero spread
		for (int unsigned i = 0; i < SetSize; i++) begin
			pending_samples.push_back(16'(SampleMax));
		end
		drain_pending();

		// random phases with the four idling patterns
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			queue_random(400);
			drain_pending();
		end

		// back-pressure phase: full-rate sender against a held-off receiver
		@(negedge clk);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_go    = 1'b1;
		queue_random(6 * SetSize);
		drain_pending();

		// let the last beat go in and every outstanding result come out
		while (s_tvalid || stats_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sample_mean_variance_stddev_core.f @@
hw/rtl/smvs_pkg.sv
hw/rtl/smvs_dp.sv
hw/rtl/smvs_ctrl.sv
hw/rtl/sample_mean_variance_stddev_core.sv
verif/tb.sv
